>>> hw/rtl/wlvt_pkg.sv
// Shared definitions for the weighted label vote table.
// Holds parameter defaults, function codes, stream field widths and the FSM type.
// No dependencies.
`timescale 1ns / 1ps

package wlvt_pkg;

    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_LABEL_BITS    = 16;
    localparam int DEF_ACC_BITS      = 32;

    localparam int IN_ID_BITS     = 16;
    localparam int IN_WT_BITS     = 16;
    localparam int FUNC_BITS      = 2;
    localparam int PROB_BITS      = 16;
    localparam int LEADER_BITS    = 17;
    localparam int IN_DATA_BITS   = 32;
    localparam int OUT_DATA_BITS  = 40;
    localparam int OUT_FILL_BITS  = OUT_DATA_BITS - PROB_BITS - LEADER_BITS - 3;
    localparam int DIV_CNT_BITS   = $clog2(PROB_BITS);

    typedef logic [FUNC_BITS-1:0] t_func;

    localparam t_func FUNC_ADD   = 2'd0;
    localparam t_func FUNC_QUERY = 2'd1;
    localparam t_func FUNC_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ADD,
        S_WRITE,
        S_QCHK,
        S_DIV,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/weighted_label_vote_table.sv
// Weighted label vote table: top level, FSM, entry memory and divider.
// Depends on wlvt_pkg.
//
// Each transfer carries one command (add, query, clear) and yields exactly one result
// transfer. Labels and weights sit in one entry memory with a registered read; valid
// bits are flip-flops cleared by reset and by a clear command. Add and query scan the
// memory one entry per cycle, stopping at the first match. An add then computes the
// saturating sums (S_ADD) and does the write-back (S_WRITE). A query runs a radix-2
// restoring divider that makes one quotient bit a cycle. A new command is taken while
// the previous result still waits in the output register.
`timescale 1ns / 1ps

module weighted_label_vote_table #(
    parameter int TABLE_ENTRIES = wlvt_pkg::DEF_TABLE_ENTRIES,
    parameter int LABEL_BITS    = wlvt_pkg::DEF_LABEL_BITS,
    parameter int ACC_BITS      = wlvt_pkg::DEF_ACC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // label_id [15:0], vote_weight [31:16]
    input  logic [wlvt_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // func [1:0]
    input  logic [wlvt_pkg::FUNC_BITS-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // probability [15:0], leader_label [32:16], leader_is_owner [33],
    // observed [34], table_full [35], zero fill [39:36]
    output logic [wlvt_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

    import wlvt_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int WW = LABEL_BITS + ACC_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};
    localparam logic [PROB_BITS-1:0] PROB_MAX = {PROB_BITS{1'b1}};

    logic [WW-1:0] mem [TABLE_ENTRIES];
    logic [WW-1:0] r_mem_q;
    logic [IW-1:0] rd_addr;
    logic          mem_we;

    t_state r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [ACC_BITS-1:0]      r_total, n_total;
    logic [ACC_BITS-1:0]      r_leader_wt, n_leader_wt;
    logic [LABEL_BITS-1:0]    r_leader_id, n_leader_id;
    logic                     r_leader_none, n_leader_none;

    t_func                    r_func, n_func;
    logic [LABEL_BITS-1:0]    r_id, n_id;
    logic [IN_WT_BITS-1:0]    r_wt, n_wt;
    logic [IW-1:0]            r_idx, n_idx;
    logic [IW-1:0]            r_slot, n_slot;
    logic [IW-1:0]            r_free, n_free;
    logic                     r_free_ok, n_free_ok;
    logic [ACC_BITS-1:0]      r_old_wt, n_old_wt;
    logic [ACC_BITS-1:0]      r_new_wt, n_new_wt;
    logic [ACC_BITS-1:0]      r_new_tot, n_new_tot;
    logic [ACC_BITS-1:0]      r_rem, n_rem;
    logic [PROB_BITS-1:0]     r_quo, n_quo;
    logic [DIV_CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [PROB_BITS-1:0]     r_prob, n_prob;
    logic                     r_full, n_full;
    logic                     r_out_valid, n_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data, n_out_data;

    logic                     in_xfer;
    logic [LABEL_BITS-1:0]    q_label;
    logic [ACC_BITS-1:0]      q_weight;
    logic                     hit_now;
    logic                     free_now;
    logic [ACC_BITS:0]        sum_ent;
    logic [ACC_BITS:0]        sum_tot;
    logic [ACC_BITS:0]        rem_sh;
    logic                     quo_bit;
    logic [LEADER_BITS-1:0]   leader_lbl;
    logic                     leader_own;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign q_label  = r_mem_q[WW-1:ACC_BITS];
    assign q_weight = r_mem_q[ACC_BITS-1:0];
    assign hit_now  = r_valid[r_idx] && (q_label == r_id);
    assign free_now = !r_valid[r_idx] && !r_free_ok;
    assign sum_ent  = {1'b0, r_old_wt} + {{(ACC_BITS + 1 - IN_WT_BITS){1'b0}}, r_wt};
    assign sum_tot  = {1'b0, r_total} + {{(ACC_BITS + 1 - IN_WT_BITS){1'b0}}, r_wt};
    assign rem_sh   = {r_rem, 1'b0};
    assign quo_bit  = (rem_sh >= {1'b0, r_total});
    assign leader_lbl = r_leader_none ? {LEADER_BITS{1'b1}} : LEADER_BITS'(r_leader_id);
    assign leader_own = !r_leader_none && (r_leader_id == '0);

    assign rd_addr = (r_state == S_SCAN) ? IW'(r_idx + 1'b1) : '0;
    assign mem_we  = (r_state == S_WRITE);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_slot] <= {r_id, r_new_wt};
        end
        r_mem_q <= mem[rd_addr];
    end

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_total       = r_total;
        n_leader_wt   = r_leader_wt;
        n_leader_id   = r_leader_id;
        n_leader_none = r_leader_none;
        n_func        = r_func;
        n_id          = r_id;
        n_wt          = r_wt;
        n_idx         = r_idx;
        n_slot        = r_slot;
        n_free        = r_free;
        n_free_ok     = r_free_ok;
        n_old_wt      = r_old_wt;
        n_new_wt      = r_new_wt;
        n_new_tot     = r_new_tot;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_cnt         = r_cnt;
        n_prob        = r_prob;
        n_full        = r_full;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_func    = s_axis_tuser;
                    n_id      = LABEL_BITS'(s_axis_tdata[IN_ID_BITS-1:0]);
                    n_wt      = s_axis_tdata[IN_ID_BITS +: IN_WT_BITS];
                    n_idx     = '0;
                    n_free_ok = 1'b0;
                    n_prob    = '0;
                    n_full    = 1'b0;
                    unique case (s_axis_tuser) inside
                        FUNC_ADD, FUNC_QUERY: n_state = S_SCAN;
                        FUNC_CLEAR: begin
                            n_valid       = '0;
                            n_total       = '0;
                            n_leader_wt   = '0;
                            n_leader_id   = '0;
                            n_leader_none = 1'b1;
                            n_state       = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit_now) begin
                    n_slot   = r_idx;
                    n_old_wt = q_weight;
                    n_state  = (r_func == FUNC_ADD) ? S_ADD : S_QCHK;
                end else begin
                    if (free_now) begin
                        n_free_ok = 1'b1;
                        n_free    = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        if (r_func != FUNC_ADD) begin
                            n_state = S_DONE;
                        end else if (r_free_ok || free_now) begin
                            n_slot   = r_free_ok ? r_free : r_idx;
                            n_old_wt = '0;
                            n_valid[r_free_ok ? r_free : r_idx] = 1'b1;
                            n_state  = S_ADD;
                        end else begin
                            n_full  = 1'b1;
                            n_state = S_DONE;
                        end
                    end else begin
                        n_idx = IW'(r_idx + 1'b1);
                    end
                end
            end
            S_ADD: begin
                n_new_wt  = sum_ent[ACC_BITS] ? ACC_MAX : sum_ent[ACC_BITS-1:0];
                n_new_tot = sum_tot[ACC_BITS] ? ACC_MAX : sum_tot[ACC_BITS-1:0];
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                n_total = r_new_tot;
                if (r_new_wt > r_leader_wt) begin
                    n_leader_wt   = r_new_wt;
                    n_leader_id   = r_id;
                    n_leader_none = 1'b0;
                end
                n_state = S_DONE;
            end
            S_QCHK: begin
                if (r_total == '0) begin
                    n_state = S_DONE;
                end else if (r_old_wt >= r_total) begin
                    n_prob  = PROB_MAX;
                    n_state = S_DONE;
                end else begin
                    n_rem   = r_old_wt;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = quo_bit ? ACC_BITS'(rem_sh - {1'b0, r_total}) : rem_sh[ACC_BITS-1:0];
                n_quo = {r_quo[PROB_BITS-2:0], quo_bit};
                n_cnt = DIV_CNT_BITS'(r_cnt + 1'b1);
                if (r_cnt == DIV_CNT_BITS'(PROB_BITS - 1)) begin
                    n_prob  = {r_quo[PROB_BITS-2:0], quo_bit};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{OUT_FILL_BITS{1'b0}}, r_full, |r_valid, leader_own,
                                   leader_lbl, r_prob};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_total       <= '0;
            r_leader_wt   <= '0;
            r_leader_id   <= '0;
            r_leader_none <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_total       <= n_total;
            r_leader_wt   <= n_leader_wt;
            r_leader_id   <= n_leader_id;
            r_leader_none <= n_leader_none;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_id       <= n_id;
        r_wt       <= n_wt;
        r_idx      <= n_idx;
        r_slot     <= n_slot;
        r_free     <= n_free;
        r_free_ok  <= n_free_ok;
        r_old_wt   <= n_old_wt;
        r_new_wt   <= n_new_wt;
        r_new_tot  <= n_new_tot;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_prob     <= n_prob;
        r_full     <= n_full;
        r_out_data <= n_out_data;
    end

    a_full_only_when_all_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_full) |-> (&r_valid))
        else $error("table_full reported with a free entry");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tuser == FUNC_CLEAR)
            |=> (r_valid == '0 && r_total == '0 && r_leader_none))
        else $error("clear left state behind");

    a_div_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_total))
        else $error("divider remainder out of range");

    a_leader_within_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leader_wt <= r_total)
        else $error("leader weight exceeds total");

endmodule
